### design/bsr_pkg.sv
// Shared constants, types and helpers for the bitstream reader.
// Used by bsr_bit_extract and mpeg_bitstream_reader_unit; depends on nothing.
package bsr_pkg;

  // request kinds
  localparam logic [2:0] KIND_APPEND  = 3'd0;
  localparam logic [2:0] KIND_PEEK    = 3'd1;
  localparam logic [2:0] KIND_CONSUME = 3'd2;
  localparam logic [2:0] KIND_SKIP    = 3'd3;
  localparam logic [2:0] KIND_ALIGN   = 3'd4;
  localparam logic [2:0] KIND_FIND    = 3'd5;
  localparam logic [2:0] KIND_COMPARE = 3'd6;

  localparam int POS_W     = 20;
  localparam int READ_BITS = 32;
  localparam int WIN_W     = READ_BITS + 8;
  // byte index of a bit position plus a 32-bit overrun needs 18 bits
  localparam int IDX_MIN_W = POS_W - 2;
  localparam int POS_MAX_BYTE = (1 << (POS_W - 3)) - 1;

  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [READ_BITS-1:0] word_t;
  typedef logic [WIN_W-1:0]     win_t;
  typedef logic [5:0]           cnt_t;

  localparam pos_t POS_MAX       = {POS_W{1'b1}};
  localparam pos_t POS_LAST_BYTE = {{(POS_W-3){1'b1}}, 3'b000};

  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [7:0] ONE_BYTE  = 8'h01;

  // advance, saturating at the last bit position
  function automatic pos_t pos_advance(pos_t p, cnt_t n);
    logic [POS_W:0] s;
    s = {1'b0, p} + {{(POS_W-5){1'b0}}, n};
    return s[POS_W] ? POS_MAX : s[POS_W-1:0];
  endfunction

  // round up to a byte boundary, clamp to the last one
  function automatic pos_t pos_align(pos_t p);
    logic [POS_W:0] s;
    s = {1'b0, p} + (POS_W+1)'(7);
    return s[POS_W] ? POS_LAST_BYTE : {s[POS_W-1:3], 3'b000};
  endfunction

endpackage

### design/bsr_byte_mem.sv
// Synchronous byte store: one write port, one read port, registered read data.
// Standalone; no package dependency.
module bsr_byte_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/bsr_bit_extract.sv
// Pulls the requested bits out of the fetched byte window, right aligned.
// Depends on bsr_pkg for window and word types.
module bsr_bit_extract (
  input  bsr_pkg::win_t  win,
  input  logic [2:0]     off,
  input  bsr_pkg::cnt_t  n,
  output bsr_pkg::word_t bits
);
  import bsr_pkg::*;

  logic [2:0]         tail;
  win_t               shifted;
  logic [READ_BITS:0] mask;

  // drop the bits after the last wanted one, then keep n bits
  assign tail    = 3'd0 - (off + n[2:0]);
  assign shifted = win >> tail;
  assign mask    = ((READ_BITS+1)'(1) << n) - (READ_BITS+1)'(1);
  assign bits    = shifted[READ_BITS-1:0] & mask[READ_BITS-1:0];

endmodule

### design/mpeg_bitstream_reader_unit.sv
// Bitstream reader for an MPEG-1 style decoder.
// Requests come in on start/busy: a request is taken at a clock edge where start is
// high and busy is low. kind selects append, peek, consume, skip, align, start-code
// search or compare; count (saturated at 32) sizes bit reads.
// Every request gives one result on bits_out, matches_res, start_code_byte and
// past_end, shown for exactly one cycle with done high; the receiver cannot stall,
// so it must take the result in that cycle.
// append, skip, align and unused kinds go straight to the result state.
// peek, consume, compare read nb = ceil((bit offset + count) / 8) bytes, at most 5;
// the byte memory is read one byte per cycle on its single port.
// start-code search scans bytes from the aligned position until the prefix or the end.
// Bytes past the loaded length read as zero and set past_end.
// rst (synchronous) clears position, loaded length and control; the byte store
// itself is not cleared, only loaded entries are ever used.
module mpeg_bitstream_reader_unit #(
  parameter int STORE_BYTES = 65536
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            kind,
  input  bsr_pkg::cnt_t         count,
  input  logic [7:0]            byte_value,
  input  bsr_pkg::word_t        compare_value,
  output logic                  done,
  output bsr_pkg::word_t        bits_out,
  output logic                  matches_res,
  output logic [7:0]            start_code_byte,
  output logic                  past_end
);
  import bsr_pkg::*;

  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int LW = AW + 1;
  localparam int IW = (LW > IDX_MIN_W) ? LW : IDX_MIN_W;
  localparam logic [LW-1:0] STORE_LIMIT = LW'(STORE_BYTES);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FETCH  = 3'd1;
  localparam logic [2:0] ST_SEARCH = 3'd2;
  localparam logic [2:0] ST_TAIL   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]    state;
  logic [2:0]    kind_q;
  cnt_t          n_q;
  logic [2:0]    off_q;
  word_t         cval_q;
  pos_t          bit_position;
  logic [LW-1:0] loaded;
  logic [IW-1:0] issue_idx;
  logic [2:0]    issue_left;
  logic          pend;
  logic          pend_zero;
  logic [IW-1:0] pend_idx;
  win_t          win;
  logic [1:0]    got;
  logic [7:0]    scb_q;
  logic          beyond_q;

  logic          wr_en;
  logic          rd_en;
  logic [7:0]    rd_data;
  cnt_t          cnt_sat;
  logic [2:0]    nb;
  pos_t          pos_aligned;
  logic [IW-1:0] loaded_ext;
  logic          issue_in_range;
  logic [7:0]    cap_byte;
  win_t          win_shift;
  logic [1:0]    got_next;
  logic          found;
  logic [IW-1:0] found_idx;
  pos_t          found_pos;
  logic [IW-1:0] search_idx;
  logic          nf_move;
  pos_t          nf_pos;
  word_t         ext_bits;
  logic          is_read;

  assign busy        = (state != ST_IDLE);
  assign cnt_sat     = (count > cnt_t'(READ_BITS)) ? cnt_t'(READ_BITS) : count;
  assign nb          = (cnt_sat == '0) ? 3'd0
                     : 3'((7'(bit_position[2:0]) + 7'(cnt_sat) + 7'd7) >> 3);
  assign pos_aligned = pos_align(bit_position);
  assign loaded_ext  = IW'(loaded);

  assign issue_in_range = (issue_idx < loaded_ext);
  assign rd_en = issue_in_range &&
                 ((state == ST_FETCH && issue_left != 3'd0) || state == ST_SEARCH);
  assign wr_en = (state == ST_IDLE) && start && (kind == KIND_APPEND) &&
                 (loaded < STORE_LIMIT);

  // unloaded bytes read as zero
  assign cap_byte  = pend_zero ? ZERO_BYTE : rd_data;
  assign win_shift = {win[WIN_W-9:0], cap_byte};
  assign got_next  = (got == 2'd3) ? 2'd3 : got + 2'd1;
  assign found     = (state == ST_SEARCH) && pend && (got_next == 2'd3) &&
                     (win_shift[23:0] == {ZERO_BYTE, ZERO_BYTE, ONE_BYTE});
  assign found_idx = pend_idx - IW'(2);
  assign found_pos = {found_idx[POS_W-4:0], 3'b000};

  // no code found: move to the end of the loaded bytes if that lies ahead
  assign search_idx = IW'(bit_position[POS_W-1:3]);
  assign nf_move    = (search_idx < loaded_ext) && (loaded_ext <= IW'(POS_MAX_BYTE));
  assign nf_pos     = {loaded_ext[POS_W-4:0], 3'b000};

  assign is_read = (kind_q == KIND_PEEK) || (kind_q == KIND_CONSUME) ||
                   (kind_q == KIND_COMPARE);

  bsr_byte_mem #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (loaded[AW-1:0]),
    .wr_data (byte_value),
    .rd_en   (rd_en),
    .rd_addr (issue_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  bsr_bit_extract u_extract (
    .win  (win),
    .off  (off_q),
    .n    (n_q),
    .bits (ext_bits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      bit_position <= '0;
      loaded       <= '0;
      pend         <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            kind_q     <= kind;
            n_q        <= cnt_sat;
            off_q      <= bit_position[2:0];
            cval_q     <= compare_value;
            win        <= '0;
            got        <= 2'd0;
            scb_q      <= ZERO_BYTE;
            beyond_q   <= 1'b0;
            pend       <= 1'b0;
            pend_zero  <= 1'b0;
            issue_idx  <= IW'(bit_position[POS_W-1:3]);
            issue_left <= nb;
            state      <= ST_FINISH;
            case (kind)
              KIND_APPEND: begin
                if (loaded < STORE_LIMIT) begin
                  loaded <= loaded + LW'(1);
                end
              end
              KIND_PEEK, KIND_CONSUME, KIND_COMPARE: begin
                state <= ST_FETCH;
              end
              KIND_SKIP: begin
                bit_position <= pos_advance(bit_position, cnt_sat);
              end
              KIND_ALIGN: begin
                bit_position <= pos_aligned;
              end
              KIND_FIND: begin
                bit_position <= pos_aligned;
                issue_idx    <= IW'(pos_aligned[POS_W-1:3]);
                state        <= ST_SEARCH;
              end
              default: begin
              end
            endcase
          end
        end
        ST_FETCH: begin
          // issue one byte per cycle, capture it in the cycle after the read
          if (issue_left != 3'd0) begin
            issue_idx  <= issue_idx + IW'(1);
            issue_left <= issue_left - 3'd1;
            pend       <= 1'b1;
            pend_zero  <= !issue_in_range;
          end else begin
            pend  <= 1'b0;
            state <= ST_FINISH;
          end
          if (pend) begin
            win <= win_shift;
            if (pend_zero) begin
              beyond_q <= 1'b1;
            end
          end
        end
        ST_SEARCH: begin
          if (issue_in_range) begin
            issue_idx <= issue_idx + IW'(1);
            pend      <= 1'b1;
            pend_idx  <= issue_idx;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            win <= win_shift;
            got <= got_next;
          end
          if (found) begin
            // the byte after the prefix is already in flight if it is loaded
            bit_position <= found_pos;
            state        <= ST_TAIL;
          end else if (!pend && !issue_in_range) begin
            beyond_q <= 1'b1;
            if (nf_move) begin
              bit_position <= nf_pos;
            end
            state <= ST_FINISH;
          end
        end
        ST_TAIL: begin
          pend <= 1'b0;
          if (pend) begin
            scb_q <= rd_data;
          end else begin
            beyond_q <= 1'b1;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          done            <= 1'b1;
          bits_out        <= is_read ? ext_bits : '0;
          matches_res     <= (kind_q == KIND_COMPARE) && (ext_bits == cval_q);
          start_code_byte <= scb_q;
          past_end        <= beyond_q;
          if (kind_q == KIND_CONSUME) begin
            bit_position <= pos_advance(bit_position, n_q);
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding work");

  a_loaded_limit: assert property (@(posedge clk) disable iff (rst)
    loaded <= STORE_LIMIT)
    else $error("loaded length beyond store size");

  a_aligned_end: assert property (@(posedge clk) disable iff (rst)
    done && (kind_q == KIND_ALIGN || kind_q == KIND_FIND) |-> bit_position[2:0] == 3'd0)
    else $error("align or search left an unaligned position");

  a_read_in_flight: assert property (@(posedge clk) disable iff (rst)
    pend && !pend_zero |-> $past(rd_en))
    else $error("byte captured without a memory read");

endmodule
